/* sv/base64_stream_decoder_defines.svh */
// assertion macros for the base64 stream decoder checker
// used by base64_stream_decoder_checker.sv, expects i_clk and i_rst_n in scope
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// condition implies consequence in the same cycle, outside reset
`define B64D_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition implies consequence in the next cycle, outside reset
`define B64D_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/b64d_pkg.sv */
// shared types, constants and the character classifier of the base64 decoder
// no dependencies
`default_nettype none

package b64d_pkg;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] POS_LAST   = 2'd3;
    localparam logic [1:0] PAD_MAX    = 2'd3;
    localparam logic [1:0] BYTES_FULL = 2'd3;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_PAD,
        KIND_SPACE,
        KIND_BAD
    } t_char_kind;

    typedef struct packed {
        t_char_kind kind;
        logic [5:0] value;
    } t_class;

    // one decoded quartet or one error, as handed to the back end
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  count;
        logic        bad;
    } t_group;

    // map an ascii byte onto the standard base64 alphabet
    function automatic t_class classify(input logic [7:0] ch);
        t_class c;
        c.kind  = KIND_DATA;
        c.value = 6'd0;
        priority if (ch >= "A" && ch <= "Z") begin
            c.value = 6'(ch - 8'h41);
        end else if (ch >= "a" && ch <= "z") begin
            c.value = 6'(ch - 8'h61 + 8'd26);
        end else if (ch >= "0" && ch <= "9") begin
            c.value = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == "+") begin
            c.value = 6'd62;
        end else if (ch == "/") begin
            c.value = 6'd63;
        end else if (ch == "=") begin
            c.kind = KIND_PAD;
        end else if (ch == " " || (ch >= 8'd9 && ch <= 8'd13)) begin
            c.kind = KIND_SPACE;
        end else begin
            c.kind = KIND_BAD;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/b64d_front.sv */
// front end: accepts characters, classifies them and assembles quartets
// depends on b64d_pkg
`default_nettype none

module b64d_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic [7:0]      i_in_char,
    input  wire logic            i_q_full,
    output logic                 o_full,
    output logic                 o_q_push,
    output b64d_pkg::t_group     o_q_data
);
    import b64d_pkg::*;

    logic [17:0] r_store, n_store;
    logic [1:0]  r_pos,   n_pos;
    logic [1:0]  r_pad,   n_pad;
    logic        r_halted, n_halted;

    t_class      cls;
    logic        accept;
    logic [5:0]  sextet;
    logic [1:0]  pad_inc;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign cls    = classify(i_in_char);
    assign sextet = (cls.kind == KIND_PAD) ? 6'd0 : cls.value;

    // quartet assembly and result hand-off
    always_comb begin
        n_store  = r_store;
        n_pos    = r_pos;
        n_pad    = r_pad;
        n_halted = r_halted;
        pad_inc  = r_pad;
        o_q_push = 1'b0;
        o_q_data = '{word: 24'd0, count: 2'd1, bad: 1'b1};
        if (cls.kind == KIND_PAD && r_pad != PAD_MAX) begin
            pad_inc = r_pad + 2'd1;
        end
        if (accept && !r_halted) begin
            unique case (cls.kind)
                KIND_SPACE: begin
                end
                KIND_BAD: begin
                    n_halted = 1'b1;
                    n_store  = '0;
                    n_pos    = '0;
                    n_pad    = '0;
                    o_q_push = 1'b1;
                end
                KIND_DATA, KIND_PAD: begin
                    if (r_pos != POS_LAST) begin
                        n_store = {r_store[11:0], sextet};
                        n_pos   = r_pos + 2'd1;
                        n_pad   = pad_inc;
                    end else begin
                        o_q_data.word  = {r_store, sextet};
                        o_q_data.count = BYTES_FULL - pad_inc;
                        o_q_data.bad   = 1'b0;
                        o_q_push       = (pad_inc != PAD_MAX);
                        n_store        = '0;
                        n_pos          = '0;
                        n_pad          = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store  <= '0;
            r_pos    <= '0;
            r_pad    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_store  <= n_store;
            r_pos    <= n_pos;
            r_pad    <= n_pad;
            r_halted <= n_halted;
        end
    end

endmodule

`default_nettype wire

/* sv/b64d_queue.sv */
// short queue of decoded groups between front and back end
// depends on b64d_pkg
`default_nettype none

module b64d_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  b64d_pkg::t_group     i_data,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output b64d_pkg::t_group     o_data
);
    import b64d_pkg::*;

    localparam logic [QUEUE_AW:0] DepthCount = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    t_group              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == DepthCount);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/b64d_back.sv */
// back end: unpacks queued groups into bytes, one item per cycle while the receiver pops
// depends on b64d_pkg
`default_nettype none

module b64d_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  b64d_pkg::t_group     i_q_data,
    output logic                 o_q_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_data_byte,
    output logic                 o_last_of_group,
    output logic                 o_bad_char
);
    import b64d_pkg::*;

    logic [23:0] r_word;
    logic [1:0]  r_left;
    logic        r_bad;
    logic        r_valid;
    logic        take;
    logic        done;

    assign o_empty         = !r_valid;
    assign o_data_byte     = r_word[23:16];
    assign o_last_of_group = (r_left == 2'd1);
    assign o_bad_char      = r_bad;

    assign take    = i_pop && r_valid;
    assign done    = !r_valid || (take && o_last_of_group);
    assign o_q_pop = done && !i_q_empty;

    // output holding register, shifts one byte out per taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
            r_bad   <= 1'b0;
            r_word  <= '0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            r_word  <= i_q_data.word;
            r_left  <= i_q_data.count;
            r_bad   <= i_q_data.bad;
        end else if (take) begin
            r_word  <= {r_word[15:0], 8'd0};
            r_left  <= r_left - 2'd1;
            if (o_last_of_group) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/base64_stream_decoder.sv */
// Base64 stream decoder: one ASCII character per input item, standard alphabet,
// whitespace skipped, '=' counted as padding. A fourth non-whitespace character
// yields three, two or one bytes (none, one or two pads), the last one marked; three
// or more pads in a quartet yield nothing. Any other character yields one error item
// (data 0, last and bad set) and the block then drops all input until reset. Input
// is taken every cycle while the two-entry group queue has room; bytes leave one
// per cycle from the output register while the receiver pops, so four characters
// per three bytes keep up. Bytes pass the group queue, then the output register.
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
`default_nettype none

module base64_stream_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_in_char,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_data_byte,
    output logic            o_last_of_group,
    output logic            o_bad_char
);
    import b64d_pkg::*;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    t_group q_wdata;
    t_group q_rdata;

    // character intake and quartet assembly
    b64d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_in_char (i_in_char),
        .i_q_full  (q_full),
        .o_full    (o_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    // group queue
    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // byte output
    b64d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_data_byte     (o_data_byte),
        .o_last_of_group (o_last_of_group),
        .o_bad_char      (o_bad_char)
    );

endmodule

`default_nettype wire

/* sv/base64_stream_decoder_checker.sv */
// port-level checks for the base64 stream decoder, bound to the top level
// depends on base64_stream_decoder_defines.svh
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module base64_stream_decoder_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_push,
    input wire logic       o_full,
    input wire logic [7:0] i_in_char,
    input wire logic       o_empty,
    input wire logic       i_pop,
    input wire logic [7:0] o_data_byte,
    input wire logic       o_last_of_group,
    input wire logic       o_bad_char
);

    // an error item is a lone zero byte that closes its group
    `B64D_ASSERT_NOW(a_bad_form, (!o_empty && o_bad_char), (o_last_of_group && o_data_byte == 8'd0), "error item malformed")

    // nothing follows an error item once it is taken
    `B64D_ASSERT_NEXT(a_bad_halts, (!o_empty && i_pop && o_bad_char), o_empty, "item after error")

    // an item that is not taken stays put
    `B64D_ASSERT_NEXT(a_out_hold, (!o_empty && !i_pop), (!o_empty && $stable(o_data_byte) && $stable(o_last_of_group) && $stable(o_bad_char)), "waiting item changed")

endmodule

bind base64_stream_decoder base64_stream_decoder_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_push          (i_push),
    .o_full          (o_full),
    .i_in_char       (i_in_char),
    .o_empty         (o_empty),
    .i_pop           (i_pop),
    .o_data_byte     (o_data_byte),
    .o_last_of_group (o_last_of_group),
    .o_bad_char      (o_bad_char)
);

`default_nettype wire

/* tb/base64_stream_decoder_checker.sv */
`timescale 1ns / 1ps
// checker for the base64 stream decoder: predicts the bytes of every accepted
// character and compares them with each item popped from the block
// depends on b64d_pkg for the character kinds
module base64_stream_decoder_tb_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_in_char,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_of_group,
    input  logic       i_bad_char,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    import b64d_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_decoded;

    // bytes still owed by the block, oldest first
    t_decoded    owed_bytes[$];

    // decoder state as the block should hold it
    logic [17:0] sextets;
    logic [1:0]  slot;
    logic [1:0]  pads;
    logic        halted;

    int fails     = 0;
    int checked   = 0;
    int pending_q = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;
    assign o_pending    = pending_q;

    always @(posedge i_clk) begin : track
        t_char_kind  kind;
        logic [5:0]  val;
        logic [23:0] word;
        t_decoded    got;
        t_decoded    want;
        int          n;
        int          k;

        if (!i_rst_n) begin
            sextets = '0;
            slot    = '0;
            pads    = '0;
            halted  = 1'b0;
            owed_bytes.delete();
        end else begin
            // compare a popped item with the oldest owed byte
            if (i_pop && !i_empty) begin
                got.data = i_data_byte;
                got.last = i_last_of_group;
                got.bad  = i_bad_char;
                if (owed_bytes.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected item: data %h last %b bad %b",
                                 got.data, got.last, got.bad);
                end else begin
                    want = owed_bytes.pop_front();
                    checked++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected data %h last %b bad %b, got data %h last %b bad %b",
                                     want.data, want.last, want.bad,
                                     got.data, got.last, got.bad);
                    end
                end
            end

            // predict the bytes of an accepted character
            if (i_push && !i_full && !halted) begin
                kind = KIND_DATA;
                val  = 6'd0;
                if (i_in_char >= "A" && i_in_char <= "Z")
                    val = 6'(i_in_char - "A");
                else if (i_in_char >= "a" && i_in_char <= "z")
                    val = 6'(i_in_char - "a" + 8'd26);
                else if (i_in_char >= "0" && i_in_char <= "9")
                    val = 6'(i_in_char - "0" + 8'd52);
                else if (i_in_char == "+")
                    val = 6'd62;
                else if (i_in_char == "/")
                    val = 6'd63;
                else if (i_in_char == "=")
                    kind = KIND_PAD;
                else if (i_in_char == " " || (i_in_char >= 8'h09 && i_in_char <= 8'h0D))
                    kind = KIND_SPACE;
                else
                    kind = KIND_BAD;

                case (kind)
                    KIND_SPACE: begin
                    end
                    KIND_BAD: begin
                        // error item, partial quartet dropped, input ignored from now on
                        halted    = 1'b1;
                        sextets   = '0;
                        slot      = '0;
                        pads      = '0;
                        want.data = 8'h00;
                        want.last = 1'b1;
                        want.bad  = 1'b1;
                        owed_bytes.push_back(want);
                    end
                    default: begin
                        if (kind == KIND_PAD && pads != 2'd3)
                            pads++;
                        if (slot != 2'd3) begin
                            sextets = {sextets[11:0], val};
                            slot++;
                        end else begin
                            // quartet complete: three bytes less one per pad
                            word = {sextets, val};
                            n    = 3 - int'(pads);
                            for (k = 0; k < n; k++) begin
                                want.data = word[23 - 8 * k -: 8];
                                want.last = (k == n - 1);
                                want.bad  = 1'b0;
                                owed_bytes.push_back(want);
                            end
                            sextets = '0;
                            slot    = '0;
                            pads    = '0;
                        end
                    end
                endcase
            end
        end
        pending_q <= owed_bytes.size();
    end

endmodule

/* tb/base64_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// testbench top for the base64 stream decoder: drives characters and pops bytes
// under several idle patterns; depends on base64_stream_decoder and its checker
module base64_stream_decoder_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 45;

    localparam logic [7:0] PAD_CHAR = "=";

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       push    = 1'b0;
    logic [7:0] in_char = 8'h00;
    logic       pop     = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] data_byte;
    logic       last_of_group;
    logic       bad_char;

    int fail_count;
    int pending;
    int checked;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int chars_sent   = 0;
    int stall_cycles = 0;

    always #1 clk = ~clk;

    base64_stream_decoder u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_in_char       (in_char),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_data_byte     (data_byte),
        .o_last_of_group (last_of_group),
        .o_bad_char      (bad_char)
    );

    base64_stream_decoder_tb_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_in_char       (in_char),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_data_byte     (data_byte),
        .i_last_of_group (last_of_group),
        .i_bad_char      (bad_char),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_request != 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles in which no item moves
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one character, idling at random first, until the block takes it
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_char <= ch;
        @(posedge clk);
        while (full)
            @(posedge clk);
        chars_sent++;
    endtask

    // stop offering and wait until every owed byte has been popped
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26)
            return "A" + 8'(v);
        else if (v < 6'd52)
            return "a" + 8'(v) - 8'd26;
        else if (v < 6'd62)
            return "0" + 8'(v) - 8'd52;
        else if (v == 6'd62)
            return "+";
        return "/";
    endfunction

    // space, tab, lf, vt, ff, cr
    function automatic logic [7:0] space_char();
        case ($urandom_range(5))
            0:       return " ";
            1:       return 8'h09;
            2:       return 8'h0A;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    // one quartet, zero to four pads trailing or scattered, a little whitespace
    task automatic send_quartet();
        logic [3:0] pad_mask;
        int         n_pad;
        int         placed;
        int         roll;
        int         slot;

        roll     = $urandom_range(99);
        n_pad    = (roll < 50) ? 0 : (roll < 70) ? 1 : (roll < 88) ? 2 : (roll < 95) ? 3 : 4;
        pad_mask = 4'b0000;
        placed   = 0;
        if ($urandom_range(1) == 0) begin
            for (slot = 0; slot < n_pad; slot++)
                pad_mask[3 - slot] = 1'b1;
        end else begin
            while (placed < n_pad) begin
                slot = $urandom_range(3);
                if (!pad_mask[slot]) begin
                    pad_mask[slot] = 1'b1;
                    placed++;
                end
            end
        end
        for (slot = 0; slot < 4; slot++) begin
            if ($urandom_range(9) == 0)
                send_char(space_char());
            send_char(pad_mask[slot] ? PAD_CHAR : sextet_char(6'($urandom_range(63))));
        end
    endtask

    initial begin
        // range ends, all whitespace, pads trailing, scattered and too many
        logic [7:0] directed_chars [26] = '{
            "/", "/", "/", "/",
            "Z", " ", "a", 8'h09, "z", 8'h0A, "0",
            "9", 8'h0B, "+", "/", 8'h0C, "=", 8'h0D,
            "=", "A", "=", "B",
            "A", "=", "=", "="
        };
        int ph;
        int goal;
        int i;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_chars[i])
            send_char(directed_chars[i]);
        wait_drained();

        // random phases: clean with one receiver hold-off, sender idle, receiver stall, both
        for (ph = 0; ph < 4; ph++) begin
            tx_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 32 : 0;
            rx_idle_pct = (ph == 2) ? 47 : (ph == 3) ? 32 : 0;
            if (ph == 0)
                hold_request = 1;
            goal = chars_sent + PHASE_ITEMS;
            while (chars_sent < goal) begin
                if ($urandom_range(99) < 15) begin
                    // noise: stray pad, whitespace or a lone sextet
                    case ($urandom_range(2))
                        0:       send_char(PAD_CHAR);
                        1:       send_char(space_char());
                        default: send_char(sextet_char(6'($urandom_range(63))));
                    endcase
                end else begin
                    send_quartet();
                end
            end
            wait_drained();
        end

        // partial quartet, then a bad character, then input that must be ignored
        send_char(sextet_char(6'($urandom_range(63))));
        send_char(sextet_char(6'($urandom_range(63))));
        case ($urandom_range(3))
            0:       send_char(8'h00);
            1:       send_char(8'h80 + 8'($urandom_range(127)));
            2:       send_char(8'h7F);
            default: send_char("!" + 8'($urandom_range(9)));
        endcase
        for (i = 0; i < 20; i++)
            send_char(8'($urandom_range(255)));
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d characters over clean, sender-idle, receiver-stall and mixed phases",
                 chars_sent);
        $display("checked %0d result items, ending on a bad character and ignored input",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
sv/base64_stream_decoder_checker.sv
tb/base64_stream_decoder_checker.sv
tb/base64_stream_decoder_tb.sv
